// File: sv/rsamx_pkg.sv
// rsamx_pkg: word types, register indexes and reset values for the symbol
// modular exponentiation cipher
// no dependencies
package rsamx_pkg;

  localparam int VALUE_W  = 16;
  localparam int OFFSET_W = 8;
  localparam int SHIFT_W  = 17;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PUB_EXP  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIV_EXP = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET   = 4'd3;

  localparam logic [VALUE_W-1:0]  MODULUS_RST  = 16'd3233;
  localparam logic [VALUE_W-1:0]  PUB_EXP_RST  = 16'd17;
  localparam logic [VALUE_W-1:0]  PRIV_EXP_RST = 16'd2753;
  localparam logic [OFFSET_W-1:0] OFFSET_RST   = 8'd67;

  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [VALUE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [VALUE_W-1:0] residue;
    logic [SHIFT_W-1:0] shifted_symbol;
  } out_word_t;

endpackage

// File: sv/rsa_symbol_modexp_cipher.sv
// rsa_symbol_modexp_cipher: per-symbol modular exponentiation with offset
// depends on rsamx_pkg and rsamx_modmul
//
//   channel  signals                              word
//   in       in_valid_i / in_ready_o              in_word_i (mode, value)
//   out      out_valid_o / out_ready_i            out_word_o (residue, shifted_symbol)
//   config   cfg_we_i, cfg_index_i, cfg_wdata_i   one register per write
//
// one word at a time: the base is reduced bit by bit, a negative base is
// then fixed, then per exponent bit up to its top set bit one ST_EXP step
// plus one modular multiply, two on a set bit (ST_MULA, then ST_MULS)
// a zero modulus skips straight to the result; reset restores the key
// registers; a stalled result holds the finish state but a new word is
// taken while the last result still waits
module rsa_symbol_modexp_cipher #(
  parameter int MODULUS_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  rsamx_pkg::in_word_t                 in_word_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output rsamx_pkg::out_word_t                out_word_o,
  input  logic                                cfg_we_i,
  input  logic [rsamx_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rsamx_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  import rsamx_pkg::*;

  localparam int MW = MODULUS_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_NEG,
    ST_EXP,
    ST_MULA,
    ST_MULS,
    ST_OUT
  } state_e;

  state_e              state_q;
  logic [VALUE_W-1:0]  modulus_q;
  logic [VALUE_W-1:0]  pub_exp_q;
  logic [VALUE_W-1:0]  priv_exp_q;
  logic [OFFSET_W-1:0] offset_q;
  logic [VALUE_W-1:0]  exp_q;
  logic [VALUE_W-1:0]  x_q;
  logic [3:0]          cnt_q;
  logic                neg_q;
  logic [MW-1:0]       base_q;
  logic [MW-1:0]       acc_q;
  logic                out_valid_q;
  out_word_t           out_word_q;

  logic [MW-1:0]       m_eff;
  logic [MW:0]         red_t;
  logic [MW:0]         red_d;
  logic [MW-1:0]       neg_base;
  logic [VALUE_W-1:0]  res16;
  logic [SHIFT_W-1:0]  shifted;
  logic [VALUE_W-1:0]  off16;
  logic                in_ge;
  logic [VALUE_W-1:0]  x_init;
  logic                neg_init;
  logic                mm_start;
  logic [MW-1:0]       mm_a;
  logic                mm_done;
  logic [MW-1:0]       mm_p;
  logic                out_free;
  logic                out_load;

  always_comb begin
    for (int i = 0; i < MW; i++) begin
      m_eff[i] = (i < VALUE_W) ? modulus_q[i] : 1'b0;
    end
    for (int i = 0; i < VALUE_W; i++) begin
      res16[i] = (i < MW) ? acc_q[i] : 1'b0;
    end
  end

  assign red_t    = {base_q, x_q[VALUE_W-1]};
  assign red_d    = (red_t >= {1'b0, m_eff}) ? red_t - {1'b0, m_eff} : red_t;
  assign neg_base = (base_q == '0) ? '0 : m_eff - base_q;
  assign shifted  = {1'b0, res16} + SHIFT_W'(offset_q);

  assign off16 = VALUE_W'(offset_q);
  assign in_ge = in_word_i.value >= off16;

  // encrypt mode, symbol below the offset: reduce the deficit and negate afterwards
  always_comb begin
    if (in_word_i.mode == MODE_ENC) begin
      x_init   = in_ge ? in_word_i.value - off16 : off16 - in_word_i.value;
      neg_init = !in_ge;
    end else begin
      x_init   = in_word_i.value;
      neg_init = 1'b0;
    end
  end

  assign mm_start = ((state_q == ST_EXP) && (exp_q != '0)) ||
                    ((state_q == ST_MULA) && mm_done);
  assign mm_a     = ((state_q == ST_EXP) && exp_q[0]) ? acc_q : base_q;
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = (state_q == ST_OUT) && out_free;

  rsamx_modmul #(
    .W(MW)
  ) u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mm_start),
    .a_i    (mm_a),
    .b_i    (base_q),
    .m_i    (m_eff),
    .done_o (mm_done),
    .p_o    (mm_p)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q  <= MODULUS_RST;
      pub_exp_q  <= PUB_EXP_RST;
      priv_exp_q <= PRIV_EXP_RST;
      offset_q   <= OFFSET_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MODULUS:  modulus_q  <= cfg_wdata_i;
        CFG_PUB_EXP:  pub_exp_q  <= cfg_wdata_i;
        CFG_PRIV_EXP: priv_exp_q <= cfg_wdata_i;
        CFG_OFFSET:   offset_q   <= cfg_wdata_i[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      exp_q       <= '0;
      x_q         <= '0;
      cnt_q       <= '0;
      neg_q       <= 1'b0;
      base_q      <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            x_q    <= x_init;
            neg_q  <= neg_init;
            base_q <= '0;
            cnt_q  <= 4'(VALUE_W - 1);
            exp_q  <= (in_word_i.mode == MODE_DEC) ? priv_exp_q : pub_exp_q;
            acc_q  <= (m_eff <= MW'(1)) ? '0 : MW'(1);
            if (m_eff == '0) begin
              state_q <= ST_OUT;
            end else begin
              state_q <= ST_REDUCE;
            end
          end
        end
        ST_REDUCE: begin
          base_q <= red_d[MW-1:0];
          x_q    <= {x_q[VALUE_W-2:0], 1'b0};
          cnt_q  <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= neg_q ? ST_NEG : ST_EXP;
          end
        end
        ST_NEG: begin
          base_q  <= neg_base;
          state_q <= ST_EXP;
        end
        ST_EXP: begin
          if (exp_q == '0) begin
            state_q <= ST_OUT;
          end else begin
            state_q <= exp_q[0] ? ST_MULA : ST_MULS;
          end
        end
        ST_MULA: begin
          if (mm_done) begin
            acc_q   <= mm_p;
            state_q <= ST_MULS;
          end
        end
        ST_MULS: begin
          if (mm_done) begin
            base_q  <= mm_p;
            exp_q   <= {1'b0, exp_q[VALUE_W-1:1]};
            state_q <= ST_EXP;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_word_q.residue        <= res16;
            out_word_q.shifted_symbol <= shifted;
            state_q                   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// File: sv/rsamx_modmul.sv
// rsamx_modmul: bit-serial modular multiplier, one multiplier bit per cycle
// from the top bit down, p = a * b mod m with a, b below m
// depends on nothing outside this file
module rsamx_modmul #(
  parameter int W = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic [W-1:0] m_i,
  output logic         done_o,
  output logic [W-1:0] p_o
);

  localparam int CW = $clog2(W);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  a_q;
  logic [W-1:0]  b_q;
  logic [W-1:0]  m_q;
  logic [W-1:0]  p_q;
  logic [W+1:0]  p2;
  logic [W+1:0]  m1;
  logic [W+1:0]  m2;
  logic [W+1:0]  pn;

  // double, add b on a set bit, then fold back below m (p2 stays under 3m)
  always_comb begin
    m1 = {2'b00, m_q};
    m2 = {1'b0, m_q, 1'b0};
    p2 = {1'b0, p_q, 1'b0} + (a_q[W-1] ? {2'b00, b_q} : '0);
    if (p2 >= m2) begin
      pn = p2 - m2;
    end else if (p2 >= m1) begin
      pn = p2 - m1;
    end else begin
      pn = p2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      a_q    <= '0;
      b_q    <= '0;
      m_q    <= '0;
      p_q    <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W - 1);
        a_q    <= a_i;
        b_q    <= b_i;
        m_q    <= m_i;
        p_q    <= '0;
      end else if (busy_q) begin
        p_q <= pn[W-1:0];
        a_q <= {a_q[W-2:0], 1'b0};
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign p_o    = p_q;

endmodule

// File: bench/testbench.sv
// testbench for rsa_symbol_modexp_cipher: directed and random symbols under changing keys,
// each result checked against a square-and-multiply predictor
// depends on rsamx_pkg and the rtl of rsa_symbol_modexp_cipher
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rsamx_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 4'd15;
  localparam int HOLD_CYCLES  = 3000;
  localparam int TAIL_CYCLES  = 600;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_WORDS  = 100;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_word_t              in_word = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_word;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic [VALUE_W-1:0]  key_mod  = MODULUS_RST;
  logic [VALUE_W-1:0]  key_pub  = PUB_EXP_RST;
  logic [VALUE_W-1:0]  key_priv = PRIV_EXP_RST;
  logic [OFFSET_W-1:0] key_off  = OFFSET_RST;

  in_word_t  symbols_to_send[$];
  out_word_t awaited[$];
  int        mismatches = 0;
  bit        steady = 1'b0;
  int        hold_req = 0;
  int        hold_seen;
  int        hold_left;
  int        in_gap;
  int        out_gap;

  rsa_symbol_modexp_cipher dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic out_word_t cipher_result(input in_word_t w);
    logic [63:0] m, off, base, deficit, acc, sq, e;
    out_word_t r;
    m = key_mod;
    off = key_off;
    acc = 0;
    if (m != 0) begin
      if (w.mode == MODE_ENC) begin
        e = key_pub;
        if (w.value >= off) begin
          base = (w.value - off) % m;
        end else begin
          deficit = (off - w.value) % m;
          base = (deficit == 0) ? 64'd0 : m - deficit;
        end
      end else begin
        e = key_priv;
        base = w.value % m;
      end
      acc = 64'd1 % m;
      sq = base;
      while (e != 0) begin
        if (e[0]) acc = (acc * sq) % m;
        sq = (sq * sq) % m;
        e = e >> 1;
      end
    end
    r.residue = acc[VALUE_W-1:0];
    r.shifted_symbol = acc[SHIFT_W-1:0] + off[SHIFT_W-1:0];
    return r;
  endfunction

  // driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && in_ready) awaited.push_back(cipher_result(in_word));
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (symbols_to_send.size() != 0) begin
          in_word <= symbols_to_send.pop_front();
          in_valid <= 1'b1;
          in_gap <= steady ? 0 : $urandom_range(0, 5);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk or negedge rst_n) begin : result_monitor
    out_word_t want;
    int unsigned draw;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap <= 0;
      hold_left <= 0;
      hold_seen <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited.size() == 0) begin
          $display("%0t: word with nothing expected, got residue %0d shifted %0d",
                   $time, out_word.residue, out_word.shifted_symbol);
          mismatches++;
        end else begin
          want = awaited.pop_front();
          if (out_word.residue !== want.residue) begin
            $display("%0t: residue expected %0d got %0d",
                     $time, want.residue, out_word.residue);
            mismatches++;
          end
          if (out_word.shifted_symbol !== want.shifted_symbol) begin
            $display("%0t: shifted_symbol expected %0d got %0d",
                     $time, want.shifted_symbol, out_word.shifted_symbol);
            mismatches++;
          end
        end
      end
      if (hold_seen != hold_req) begin
        hold_seen <= hold_req;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= (hold_left == 1);
      end else if (out_valid && out_ready) begin
        draw = steady ? 0 : $urandom_range(0, 5);
        out_gap <= draw;
        out_ready <= (draw == 0);
      end else if (out_gap != 0) begin
        out_gap <= out_gap - 1;
        out_ready <= (out_gap == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_key(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MODULUS:  key_mod = data;
      CFG_PUB_EXP:  key_pub = data;
      CFG_PRIV_EXP: key_priv = data;
      CFG_OFFSET:   key_off = data[OFFSET_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic load_keys(input logic [15:0] m, input logic [15:0] pub,
                           input logic [15:0] priv, input logic [7:0] off);
    write_key(CFG_MODULUS, m);
    write_key(CFG_PUB_EXP, pub);
    write_key(CFG_PRIV_EXP, priv);
    write_key(CFG_OFFSET, {8'($urandom), off});
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (symbols_to_send.size() != 0 || in_valid || awaited.size() != 0) @(negedge clk);
  endtask

  function automatic void queue_symbol(input logic mode, input logic [VALUE_W-1:0] value);
    in_word_t w;
    w.mode = mode;
    w.value = value;
    symbols_to_send.push_back(w);
  endfunction

  function automatic logic [15:0] pick_exponent();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(1, 16));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_modulus();
    case ($urandom_range(0, 15))
      0: return 16'h0000;
      1: return 16'h0001;
      2, 3: return 16'hFFFF;
      4, 5: return 16'($urandom_range(2, 300));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'($urandom_range(0, key_off));
      1: return 16'(key_off + key_mod * $urandom_range(0, 3));
      2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      3: return 16'(key_mod - 1);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset keys: negative base, zero base, wrapped base, field extremes
    queue_symbol(MODE_ENC, 16'd0);
    queue_symbol(MODE_ENC, 16'd66);
    queue_symbol(MODE_ENC, 16'd67);
    queue_symbol(MODE_ENC, 16'd72);
    queue_symbol(MODE_ENC, 16'd3300);
    queue_symbol(MODE_ENC, 16'hFFFF);
    queue_symbol(MODE_DEC, 16'd0);
    queue_symbol(MODE_DEC, 16'd3232);
    queue_symbol(MODE_DEC, 16'd3233);
    queue_symbol(MODE_DEC, 16'hFFFF);
    wait_drained();

    // spare indexes must leave the keys alone
    write_key(CFG_SPARE_LO, 16'h0000);
    write_key(CFG_SPARE_HI, 16'hFFFF);
    queue_symbol(MODE_ENC, 16'd100);
    wait_drained();

    load_keys(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    queue_symbol(MODE_ENC, 16'd0);
    queue_symbol(MODE_ENC, 16'hFFFF);
    queue_symbol(MODE_DEC, 16'hFFFE);
    queue_symbol(MODE_DEC, 16'hFFFF);
    wait_drained();

    // zero exponents, with modulus one and above one
    load_keys(16'd1, 16'd0, 16'd0, 8'd0);
    queue_symbol(MODE_ENC, 16'd5);
    queue_symbol(MODE_DEC, 16'd7);
    wait_drained();
    write_key(CFG_MODULUS, 16'd7);
    queue_symbol(MODE_ENC, 16'd100);
    queue_symbol(MODE_DEC, 16'd3);
    wait_drained();

    // zero modulus
    load_keys(16'd0, 16'd5, 16'd9, 8'd200);
    queue_symbol(MODE_ENC, 16'd10);
    queue_symbol(MODE_DEC, 16'd10000);
    wait_drained();

    for (int p = 0; p < RAND_PHASES; p++) begin
      steady = (p == 2);
      load_keys(pick_modulus(), pick_exponent(), pick_exponent(), 8'($urandom));
      for (int i = 0; i < PHASE_WORDS; i++) begin
        queue_symbol($urandom_range(0, 1) ? MODE_DEC : MODE_ENC, pick_value());
      end
      if (p == 5) hold_req++;
      wait_drained();
    end
    steady = 1'b0;

    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (awaited.size() != 0) begin
      $display("%0t: %0d words expected, 0 arrived", $time, awaited.size());
    end
    if (mismatches == 0 && awaited.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: rsa_symbol_modexp_cipher.f
sv/rsamx_pkg.sv
sv/rsamx_modmul.sv
sv/rsa_symbol_modexp_cipher.sv
bench/testbench.sv
